// ===== src/imt_pkg.sv =====
// shared types, character codes and helpers of the irc message tokenizer
// depends on nothing; used by the top level, the front and the back
`timescale 1ns / 1ps

package imt_pkg;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  localparam logic [3:0] MAX_PARAMS_LIMIT = 4'd15;
  localparam logic [3:0] MIN_PARAMS       = 4'd2;
  localparam logic [3:0] PARAM_CNT_MAX    = 4'd15;

  typedef enum logic [1:0] {
    KIND_BEGIN   = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_SUMMARY = 2'd2
  } item_kind_e;

  typedef enum logic [1:0] {
    CLS_PREFIX  = 2'd0,
    CLS_COMMAND = 2'd1,
    CLS_MIDDLE  = 2'd2,
    CLS_FINAL   = 2'd3
  } field_class_e;

  // one unit of work from the front to the back
  typedef struct packed {
    logic       is_eol;
    logic [7:0] data;
    logic       item_last;
  } op_t;

  typedef struct packed {
    item_kind_e   kind;
    field_class_e cls;
    logic [3:0]   idx;
    logic [7:0]   data;
    logic         has_cmd;
    logic [3:0]   pcount;
    logic         has_final;
    logic         run_last;
  } result_t;

  function automatic logic is_break(input logic [7:0] b);
    return (b == CHAR_CR) || (b == CHAR_LF);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    return ((b >= CHAR_LOW_A) && (b <= CHAR_LOW_Z)) ? (b - CASE_DIFF) : b;
  endfunction

  function automatic result_t mk_result(input item_kind_e k, input field_class_e c,
                                        input logic [3:0] i, input logic [7:0] d);
    result_t r;
    r           = '0;
    r.kind      = k;
    r.cls       = c;
    r.idx       = i;
    r.data      = d;
    return r;
  endfunction

endpackage

// ===== src/irc_message_tokenizer_core.sv =====
// top level of the irc message tokenizer: config register, front, op queue,
// back and result queue; depends on imt_pkg, imt_fifo, imt_front, imt_back
`timescale 1ns / 1ps

// Usage
//   input side is a queue: drive line_byte_i/line_end_i and raise push; a byte
//   transfers at a clock edge with push high and full low
//   result side is a queue: while empty is low the oldest result is on the
//   result ports; raising pop transfers it; run_last_o marks the final result
//   caused by one input byte (bytes that cause nothing give no result)
//   cfg_data_i sets max_params on a transfer with cfg_valid_i and cfg_ready_o
//   high; cfg_ready_o is always high; write it only while the block is idle
// Flow
//   an ordinary byte occupies the input side while it transfers and while its
//   op is issued; every held cr/lf released before it is issued first, and a
//   line end adds a line-end op after it; the back parser turns out one result
//   per cycle while the result queue is not full; a byte that opens a field
//   and belongs to it gives two results
// Reset and stall
//   reset empties both queues, clears the parse and hold state and sets
//   max_params to 15; no clearing pass is needed
//   when pop stays low the result queue fills, the back stops, then the op
//   queue fills and full rises; nothing is dropped

module irc_message_tokenizer_core #(
  parameter int PEND_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] line_byte_i,
  input  logic       line_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] item_kind_o,
  output logic [1:0] field_class_o,
  output logic [3:0] param_index_o,
  output logic [7:0] data_byte_o,
  output logic       has_command_o,
  output logic [3:0] param_count_o,
  output logic       has_final_o,
  output logic       run_last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i
);

  localparam int OP_DEPTH  = 4;
  localparam int RES_DEPTH = 4;
  localparam int OP_W      = $bits(imt_pkg::op_t);
  localparam int RES_W     = $bits(imt_pkg::result_t);

  logic [3:0]       max_params_q;
  logic             op_push, op_full, op_empty, op_pop;
  imt_pkg::op_t     op_in, op_out;
  logic             res_push, res_full;
  imt_pkg::result_t res_in, res_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_params_q <= imt_pkg::MAX_PARAMS_LIMIT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_params_q <= cfg_data_i;
    end
  end

  imt_front #(
    .PEND_DEPTH(PEND_DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .byte_i   (line_byte_i),
    .last_i   (line_end_i),
    .full_o   (full),
    .op_push_o(op_push),
    .op_o     (op_in),
    .op_full_i(op_full)
  );

  imt_fifo #(
    .WIDTH(OP_W),
    .DEPTH(OP_DEPTH)
  ) u_op_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (op_push),
    .data_i (op_in),
    .full_o (op_full),
    .pop_i  (op_pop),
    .data_o (op_out),
    .empty_o(op_empty)
  );

  imt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_params_i(max_params_q),
    .op_valid_i  (!op_empty),
    .op_i        (op_out),
    .op_pop_o    (op_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  imt_fifo #(
    .WIDTH(RES_W),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign item_kind_o   = res_out.kind;
  assign field_class_o = res_out.cls;
  assign param_index_o = res_out.idx;
  assign data_byte_o   = res_out.data;
  assign has_command_o = res_out.has_cmd;
  assign param_count_o = res_out.pcount;
  assign has_final_o   = res_out.has_final;
  assign run_last_o    = res_out.run_last;

endmodule

// ===== src/imt_fifo.sv =====
// small first-in first-out queue of registers, of any depth
// depends on nothing; used between front and back and on the result side
`timescale 1ns / 1ps

module imt_fifo #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [AW:0]      count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (AW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (AW+1)'(1);
      end
    end
  end

endmodule

// ===== src/imt_front.sv =====
// front: accepts line bytes, holds back cr/lf and issues content and line-end ops
// depends on imt_pkg
`timescale 1ns / 1ps

module imt_front #(
  parameter int PEND_DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  output logic           full_o,
  output logic           op_push_o,
  output imt_pkg::op_t   op_o,
  input  logic           op_full_i
);

  localparam int CW = $clog2(PEND_DEPTH + 1);
  localparam int IW = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BRK,
    S_FLUSH,
    S_EOL
  } state_e;

  state_e        state_q;
  logic [7:0]    byte_q;
  logic          last_q;
  logic [7:0]    held_q [PEND_DEPTH];
  logic [CW-1:0] cnt_q, idx_q;
  logic          accept, hold_full, flush_more, op_go;

  assign accept     = push_i && !full_o;
  assign full_o     = (state_q != S_IDLE);
  assign hold_full  = (cnt_q == CW'(PEND_DEPTH));
  assign flush_more = (idx_q < cnt_q);
  assign op_go      = op_push_o && !op_full_i;

  always_comb begin
    op_push_o = 1'b0;
    op_o      = '0;
    case (state_q)
      S_BRK: begin
        if (hold_full) begin
          op_push_o    = 1'b1;
          op_o.data    = held_q[0];
          op_o.item_last = !last_q;
        end
      end
      S_FLUSH: begin
        op_push_o = 1'b1;
        if (flush_more) begin
          op_o.data = held_q[idx_q[IW-1:0]];
        end else begin
          op_o.data      = byte_q;
          op_o.item_last = !last_q;
        end
      end
      S_EOL: begin
        op_push_o      = 1'b1;
        op_o.is_eol    = 1'b1;
        op_o.item_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= byte_i;
      last_q <= last_i;
    end
    if (state_q == S_BRK) begin
      if (hold_full) begin
        if (op_go) begin
          for (int i = 0; i < PEND_DEPTH - 1; i++) begin
            held_q[i] <= held_q[i+1];
          end
          held_q[PEND_DEPTH-1] <= byte_q;
        end
      end else begin
        held_q[cnt_q[IW-1:0]] <= byte_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            idx_q   <= '0;
            state_q <= imt_pkg::is_break(byte_i) ? S_BRK : S_FLUSH;
          end
        end
        S_BRK: begin
          if (hold_full) begin
            if (op_go) begin
              state_q <= last_q ? S_EOL : S_IDLE;
            end
          end else begin
            cnt_q   <= cnt_q + CW'(1);
            state_q <= last_q ? S_EOL : S_IDLE;
          end
        end
        S_FLUSH: begin
          if (op_go) begin
            if (flush_more) begin
              idx_q <= idx_q + CW'(1);
            end else begin
              cnt_q   <= '0;
              state_q <= last_q ? S_EOL : S_IDLE;
            end
          end
        end
        S_EOL: begin
          if (op_go) begin
            cnt_q   <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/imt_back.sv =====
// back: runs the line parser on content and line-end ops and forms the result items
// depends on imt_pkg
`timescale 1ns / 1ps

module imt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [3:0]       max_params_i,
  input  logic             op_valid_i,
  input  imt_pkg::op_t     op_i,
  output logic             op_pop_o,
  output logic             res_push_o,
  output imt_pkg::result_t res_o,
  input  logic             res_full_i
);

  typedef enum logic [2:0] {
    P_START,
    P_PREFIX,
    P_AFTER_PREFIX,
    P_COMMAND,
    P_GAP,
    P_MIDDLE,
    P_FINAL
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [3:0]       pcnt_q, pcnt_d;
  logic             cmd_q, cmd_d;
  logic             fin_q, fin_d;
  logic             pend_v_q, pend_last_q;
  imt_pkg::result_t pend_q;
  logic             hold_v_q;
  imt_pkg::result_t hold_q;

  logic             go, gen, done, done_last;
  logic [1:0]       nres;
  imt_pkg::result_t r0, r1, gen_res;
  logic [3:0]       lim, idx_cur, pcnt_inc;
  logic             limit_hit;
  logic [7:0]       b;

  assign go       = !res_full_i;
  assign op_pop_o = go && !pend_v_q && op_valid_i;
  assign b        = op_i.data;
  assign idx_cur  = pcnt_q - 4'd1;
  assign pcnt_inc = (pcnt_q < imt_pkg::PARAM_CNT_MAX) ? pcnt_q + 4'd1 : pcnt_q;

  always_comb begin
    lim = max_params_i;
    if (lim < imt_pkg::MIN_PARAMS) lim = imt_pkg::MIN_PARAMS;
    if (lim > imt_pkg::MAX_PARAMS_LIMIT) lim = imt_pkg::MAX_PARAMS_LIMIT;
  end

  assign limit_hit = ({1'b0, pcnt_q} + 5'd1) >= {1'b0, lim};

  // parser step for the op at the head of the queue
  always_comb begin
    phase_d = phase_q;
    pcnt_d  = pcnt_q;
    cmd_d   = cmd_q;
    fin_d   = fin_q;
    nres    = 2'd0;
    r0      = '0;
    r1      = '0;
    if (op_i.is_eol) begin
      nres         = 2'd1;
      r0.kind      = imt_pkg::KIND_SUMMARY;
      r0.has_cmd   = cmd_q;
      r0.pcount    = pcnt_q;
      r0.has_final = fin_q;
      phase_d      = P_START;
      pcnt_d       = '0;
      cmd_d        = 1'b0;
      fin_d        = 1'b0;
    end else begin
      unique case (phase_q) inside
        P_START, P_AFTER_PREFIX: begin
          if (b == imt_pkg::CHAR_SPACE) begin
            nres = 2'd0;
          end else if (b == imt_pkg::CHAR_COLON && phase_q == P_START) begin
            nres    = 2'd1;
            r0      = imt_pkg::mk_result(imt_pkg::KIND_BEGIN, imt_pkg::CLS_PREFIX,
                                         4'd0, 8'd0);
            phase_d = P_PREFIX;
          end else begin
            nres    = 2'd2;
            cmd_d   = 1'b1;
            phase_d = P_COMMAND;
            r0      = imt_pkg::mk_result(imt_pkg::KIND_BEGIN, imt_pkg::CLS_COMMAND,
                                         4'd0, 8'd0);
            r1      = imt_pkg::mk_result(imt_pkg::KIND_BYTE, imt_pkg::CLS_COMMAND,
                                         4'd0, imt_pkg::to_upper(b));
          end
        end
        P_PREFIX: begin
          if (b == imt_pkg::CHAR_SPACE) begin
            phase_d = P_AFTER_PREFIX;
          end else begin
            nres = 2'd1;
            r0   = imt_pkg::mk_result(imt_pkg::KIND_BYTE, imt_pkg::CLS_PREFIX, 4'd0, b);
          end
        end
        P_COMMAND: begin
          if (b == imt_pkg::CHAR_SPACE) begin
            phase_d = P_GAP;
          end else begin
            nres = 2'd1;
            r0   = imt_pkg::mk_result(imt_pkg::KIND_BYTE, imt_pkg::CLS_COMMAND,
                                      4'd0, imt_pkg::to_upper(b));
          end
        end
        P_GAP: begin
          if (b == imt_pkg::CHAR_SPACE) begin
            nres = 2'd0;
          end else if (b == imt_pkg::CHAR_COLON) begin
            nres    = 2'd1;
            fin_d   = 1'b1;
            pcnt_d  = pcnt_inc;
            phase_d = P_FINAL;
            r0      = imt_pkg::mk_result(imt_pkg::KIND_BEGIN, imt_pkg::CLS_FINAL,
                                         pcnt_q, 8'd0);
          end else if (limit_hit) begin
            nres    = 2'd2;
            fin_d   = 1'b1;
            pcnt_d  = pcnt_inc;
            phase_d = P_FINAL;
            r0      = imt_pkg::mk_result(imt_pkg::KIND_BEGIN, imt_pkg::CLS_FINAL,
                                         pcnt_q, 8'd0);
            r1      = imt_pkg::mk_result(imt_pkg::KIND_BYTE, imt_pkg::CLS_FINAL,
                                         pcnt_q, b);
          end else begin
            nres    = 2'd2;
            pcnt_d  = pcnt_inc;
            phase_d = P_MIDDLE;
            r0      = imt_pkg::mk_result(imt_pkg::KIND_BEGIN, imt_pkg::CLS_MIDDLE,
                                         pcnt_q, 8'd0);
            r1      = imt_pkg::mk_result(imt_pkg::KIND_BYTE, imt_pkg::CLS_MIDDLE,
                                         pcnt_q, b);
          end
        end
        P_MIDDLE: begin
          if (b == imt_pkg::CHAR_SPACE) begin
            phase_d = P_GAP;
          end else begin
            nres = 2'd1;
            r0   = imt_pkg::mk_result(imt_pkg::KIND_BYTE, imt_pkg::CLS_MIDDLE,
                                      idx_cur, b);
          end
        end
        P_FINAL: begin
          nres = 2'd1;
          r0   = imt_pkg::mk_result(imt_pkg::KIND_BYTE, imt_pkg::CLS_FINAL, idx_cur, b);
        end
        default: nres = 2'd0;
      endcase
    end
  end

  // one new result per cycle while the result queue is not full, op finished or not
  always_comb begin
    gen       = 1'b0;
    done      = 1'b0;
    done_last = 1'b0;
    gen_res   = r0;
    if (go) begin
      if (pend_v_q) begin
        gen       = 1'b1;
        gen_res   = pend_q;
        done      = 1'b1;
        done_last = pend_last_q;
      end else if (op_valid_i) begin
        gen       = (nres != 2'd0);
        done      = (nres != 2'd2);
        done_last = op_i.item_last;
      end
    end
    gen_res.run_last = done && done_last;
  end

  // the hold stage keeps the newest result until it is known whether it ends its run
  always_comb begin
    res_push_o = go && hold_v_q &&
                 (gen || hold_q.run_last || (done && done_last));
    res_o          = hold_q;
    res_o.run_last = hold_q.run_last || (!gen && done && done_last);
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o && nres == 2'd2) begin
      pend_q      <= r1;
      pend_last_q <= op_i.item_last;
    end
    if (gen) begin
      hold_q <= gen_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= P_START;
      pcnt_q   <= '0;
      cmd_q    <= 1'b0;
      fin_q    <= 1'b0;
      pend_v_q <= 1'b0;
      hold_v_q <= 1'b0;
    end else begin
      if (op_pop_o) begin
        phase_q  <= phase_d;
        pcnt_q   <= pcnt_d;
        cmd_q    <= cmd_d;
        fin_q    <= fin_d;
        pend_v_q <= (nres == 2'd2);
      end else if (go && pend_v_q) begin
        pend_v_q <= 1'b0;
      end
      if (gen) begin
        hold_v_q <= 1'b1;
      end else if (res_push_o) begin
        hold_v_q <= 1'b0;
      end
    end
  end

endmodule
